/* sv/rcv_pkg.sv */
// Shared types and constants for the RTCP compound datagram validator.
package rcv_pkg;

    localparam int unsigned POS_W   = 19;
    localparam int unsigned PAD_W   = 9;
    localparam int unsigned HDR_W   = 16;
    localparam int unsigned VER_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [PAD_W-1:0] PAD_START   = 9'd4;
    localparam logic [HDR_W-1:0] RST_MASK    = 16'hE0FE;
    localparam logic [HDR_W-1:0] RST_VALUE   = 16'h80C8;
    localparam logic [VER_W-1:0] RST_VERSION = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_HDR_MASK  = 2'd0,
        CFG_FIRST_HDR_VALUE = 2'd1,
        CFG_EXP_VERSION     = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_LENGTH  = 3'd1,
        ERR_MASK    = 3'd2,
        ERR_VERSION = 3'd3,
        ERR_PADDING = 3'd4
    } t_err_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic      is_valid;
        t_err_kind error_kind;
    } t_out_item;

endpackage

/* sv/rtcp_compound_validator_core.sv */
// Top level of the RTCP compound datagram validator: byte walker and result register.
// The verdict appears on o_out_valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle; every byte is handled by a single pass of counter and
// compare logic, so the input only stalls while an unread verdict blocks the result register.
// Reset (i_rst_n low, synchronous): registers return to mask 0xE0FE, value 0x80C8,
// version 2, the walker to the start of a datagram, and the result register empties.
module rtcp_compound_validator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rcv_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rcv_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_wr_en,
    input  logic [rcv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import rcv_pkg::*;

    // Configuration registers.
    logic [HDR_W-1:0] r_mask;
    logic [HDR_W-1:0] r_value;
    logic [VER_W-1:0] r_version;

    // Walker state. Only header bytes 0 and 2 are kept: byte 1 is checked as it
    // arrives, and byte 3 completes the length field as it arrives.
    logic [POS_W-1:0] r_pos,      n_pos;
    logic [POS_W-1:0] r_pkt,      n_pkt;
    logic [7:0]       r_hdr0,     n_hdr0;
    logic [7:0]       r_hdr2,     n_hdr2;
    logic             r_first,    n_first;
    logic             r_pad_mode, n_pad_mode;
    logic [PAD_W-1:0] r_pad_cnt,  n_pad_cnt;
    t_err_kind        r_err,      n_err;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out_item;
    t_err_kind kind;

    logic       accept;
    logic [7:0] b;
    logic [16:0] len_p1;

    // The result register frees up in the same cycle that its verdict is taken,
    // so a new byte can enter every cycle unless a verdict is left unread.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign b           = i_in_item.data_byte;
    assign len_p1      = {1'b0, r_hdr2, b} + 17'd1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= RST_MASK;
            r_value   <= RST_VALUE;
            r_version <= RST_VERSION;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FIRST_HDR_MASK:  r_mask    <= i_cfg_wdata;
                CFG_FIRST_HDR_VALUE: r_value   <= i_cfg_wdata;
                CFG_EXP_VERSION:     r_version <= i_cfg_wdata[VER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_pkt      = r_pkt;
        n_hdr0     = r_hdr0;
        n_hdr2     = r_hdr2;
        n_first    = r_first;
        n_pad_mode = r_pad_mode;
        n_pad_cnt  = r_pad_cnt;
        n_err      = r_err;
        kind       = ERR_NONE;

        priority if (r_err != ERR_NONE) begin
            // After an error the bytes are only counted, saturating.
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end else if (r_pad_mode) begin
            // Inside the padded last packet: count up to 256 and hold there.
            if (!r_pad_cnt[PAD_W-1]) begin
                n_pad_cnt = r_pad_cnt + 1'b1;
            end
        end else begin
            if (r_pos == '0) begin
                n_hdr0 = b;
            end
            if (r_pos == POS_W'(2)) begin
                n_hdr2 = b;
            end
            if (r_pos == POS_W'(1) && r_first && (({r_hdr0, b} & r_mask) != r_value)) begin
                n_err = ERR_MASK;
            end
            if (r_pos == POS_W'(3)) begin
                n_pkt = {len_p1, 2'b00};
                if (!r_first) begin
                    if (r_hdr0[7:6] != r_version) begin
                        n_err = ERR_VERSION;
                    end else if (r_hdr0[5]) begin
                        n_pad_mode = 1'b1;
                        n_pad_cnt  = PAD_START;
                    end
                end
            end
            n_pos = r_pos + 1'b1;
            // A complete packet wraps the position and leaves the first packet.
            if (n_err == ERR_NONE && !n_pad_mode && (n_pos[POS_W-1:2] != '0)
                    && n_pos == n_pkt) begin
                n_pos   = '0;
                n_first = 1'b0;
            end
        end

        // Verdict on the final byte, in order of precedence.
        priority if (r_first && n_first && n_pos[POS_W-1:2] == '0) begin
            kind = ERR_LENGTH;
        end else if (n_err != ERR_NONE) begin
            kind = n_err;
        end else if (n_pad_mode) begin
            kind = (n_pad_cnt == {1'b0, b}) ? ERR_NONE : ERR_PADDING;
        end else if (n_pos == '0) begin
            kind = ERR_NONE;
        end else begin
            kind = ERR_LENGTH;
        end

        // The final byte returns the walker to the start of a datagram.
        if (i_in_item.last_byte) begin
            n_pos      = '0;
            n_pkt      = '0;
            n_hdr0     = '0;
            n_hdr2     = '0;
            n_first    = 1'b1;
            n_pad_mode = 1'b0;
            n_pad_cnt  = '0;
            n_err      = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_pkt      <= '0;
            r_hdr0     <= '0;
            r_hdr2     <= '0;
            r_first    <= 1'b1;
            r_pad_mode <= 1'b0;
            r_pad_cnt  <= '0;
            r_err      <= ERR_NONE;
        end else if (accept) begin
            r_pos      <= n_pos;
            r_pkt      <= n_pkt;
            r_hdr0     <= n_hdr0;
            r_hdr2     <= n_hdr2;
            r_first    <= n_first;
            r_pad_mode <= n_pad_mode;
            r_pad_cnt  <= n_pad_cnt;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.last_byte) begin
            r_out_item.is_valid   <= (kind == ERR_NONE);
            r_out_item.error_kind <= kind;
        end
    end

endmodule

/* sv/rcv_checker.sv */
// Port-level assertions for the RTCP compound datagram validator, bound to its top level.
module rcv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input rcv_pkg::t_in_item               i_in_item,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input rcv_pkg::t_out_item              o_out_item
);
    import rcv_pkg::*;

    // A stalled verdict holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("verdict changed or dropped while stalled");

    // The pass flag agrees with the error code.
    a_pass_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_valid == (o_out_item.error_kind == ERR_NONE)))
        else $error("pass flag disagrees with error code");

    // A final byte always yields a verdict in the next cycle.
    a_final_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.last_byte |=> o_out_valid)
        else $error("final byte produced no verdict");

    // Other bytes never produce a verdict.
    a_no_extra_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_item.last_byte |=> !o_out_valid)
        else $error("verdict without a final byte");

endmodule

bind rtcp_compound_validator_core rcv_checker u_rcv_checker (.*);
